### hw/rtl/tpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the tracker pattern packer.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int MAX_BYTES = 7;
    localparam int BIDX_W    = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Commands
    localparam logic [1:0] OP_CELL    = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_ROW_END = 2'd2;
    localparam logic [1:0] OP_HEADER  = 2'd3;

    localparam logic [7:0] NOTE_EMPTY = 8'd250;
    localparam logic [7:0] NOTE_OFF   = 8'd254;
    localparam logic [7:0] NOTE_CUT   = 8'd255;
    localparam logic [8:0] NONE_VAL   = 9'd256;

    localparam logic [7:0] VOL_EMPTY_IT = 8'd255;
    localparam logic [7:0] VOL_EMPTY_XM = 8'd0;

    // Mask byte bit positions
    localparam int MB_NOTE   = 0;
    localparam int MB_INST   = 1;
    localparam int MB_VOL    = 2;
    localparam int MB_FX     = 3;
    localparam int MB_NOTE_P = 4;
    localparam int MB_INST_P = 5;
    localparam int MB_VOL_P  = 6;
    localparam int MB_FX_P   = 7;

    // Channel byte flag: a mask byte follows
    localparam int CB_MASK_FLAG = 7;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] channel;
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] volume;
        logic [7:0] effect;
        logic [7:0] effect_param;
        logic [8:0] row_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [8:0] mask;
        logic [8:0] note;
        logic [8:0] instrument;
        logic [8:0] volume;
        logic [8:0] effect;
        logic [8:0] effect_param;
    } hist_t;

    localparam int    HIST_W    = $bits(hist_t);
    localparam hist_t HIST_NONE = '{NONE_VAL, NONE_VAL, NONE_VAL, NONE_VAL, NONE_VAL, NONE_VAL};

    typedef logic [MAX_BYTES-1:0][7:0] byte_vec_t;

    typedef struct packed {
        byte_vec_t        bytes;
        logic [CNT_W-1:0] count;
        logic             wr_en;
        logic             clr_all;
        hist_t            hist;
    } enc_res_t;

endpackage

### hw/rtl/tracker_pattern_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pattern_packer
// Packs tracker pattern commands into an IT-style compressed byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one command item (cell, history clear, row
//   end or pattern header). m_valid/m_ready/m_data return the packed bytes,
//   one per cycle while m_ready is high; last_of_run marks each item's end.
//   cfg_wr_en/cfg_wr_data write xm_volume_mode (empty volume 0 or 255); write
//   it only while the block is idle.
// Path: with the output idle, an accepted item is registered in the encode
//   stage as the history RAM reads its channel; it is then encoded and
//   loaded into the output shifter, which raises m_valid with its first byte.
// Throughput: the output shifter sends one byte per cycle while m_ready is
//   high, so an item that emits k bytes (one to seven) holds the output
//   until all k are taken; an item that emits nothing skips the shifter. One
//   item waits in the encode stage while the previous item's bytes drain;
//   items of one byte or none flow at one per cycle while m_ready is high.
// Reset: all channel history reads as none at once (one valid bit per
//   channel), xm_volume_mode goes to 0 and both stages come up empty.
// Stall: when m_ready is low the shifter holds its byte, the encode stage
//   holds its item and s_ready drops until the shifter can take the next list.
// ----------------------------------------------------------------------------
module tracker_pattern_packer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  tpp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tpp_pkg::out_item_t m_data
);
    import tpp_pkg::*;

    logic                    xm_mode_reg;
    logic                    s1_valid_reg, s1_valid_next;
    in_item_t                s1_item_reg;
    logic                    s1_fwd_reg;
    hist_t                   fwd_data_reg;
    logic [NUM_CHANNELS-1:0] hvalid_reg, hvalid_next;

    logic                    accept;
    logic                    s1_advance;
    logic                    ser_can_load;
    logic                    ser_load;
    logic                    wr_en;
    logic [CH_AW-1:0]        rd_addr;
    logic [CH_AW-1:0]        s1_addr;
    logic [HIST_W-1:0]       ram_rdata;
    hist_t                   prev_eff;
    enc_res_t                res;

    assign accept  = s_valid && s_ready;
    assign rd_addr = CH_AW'(s_data.channel);
    assign s1_addr = CH_AW'(s1_item_reg.channel);

    // Advance the encode stage if it emits nothing or the shifter can load
    assign s1_advance = s1_valid_reg && ((res.count == '0) || ser_can_load);
    assign ser_load   = s1_advance && (res.count != '0);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign wr_en      = s1_advance && res.wr_en;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xm_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            xm_mode_reg <= cfg_wr_data;
        end
    end

    // Per-channel history lives in one RAM word
    tpp_hist_ram #(
        .DEPTH (NUM_CHANNELS),
        .WIDTH (HIST_W),
        .AW    (CH_AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (res.hist),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Encode stage: item plus forward of a write that lands with its read
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg  <= s_data;
            s1_fwd_reg   <= wr_en && (s1_addr == rd_addr);
            fwd_data_reg <= res.hist;
        end
    end

    // Valid bits: clear all on header or clear, set on a history write
    always_comb begin
        hvalid_next = hvalid_reg;
        if (s1_advance && res.clr_all) begin
            hvalid_next = '0;
        end else if (wr_en) begin
            hvalid_next[s1_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hvalid_reg <= '0;
        end else begin
            hvalid_reg <= hvalid_next;
        end
    end

    // Effective previous values of the item's channel
    always_comb begin
        if (!hvalid_reg[s1_addr]) begin
            prev_eff = HIST_NONE;
        end else if (s1_fwd_reg) begin
            prev_eff = fwd_data_reg;
        end else begin
            prev_eff = hist_t'(ram_rdata);
        end
    end

    tpp_encoder u_enc (
        .item           (s1_item_reg),
        .prev           (prev_eff),
        .xm_volume_mode (xm_mode_reg),
        .res            (res)
    );

    tpp_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ser_load),
        .bytes    (res.bytes),
        .count    (res.count),
        .can_load (ser_can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### hw/rtl/tpp_hist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_hist_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpp_hist_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 54,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/tpp_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_encoder
// Decodes one command against its channel history: byte list and new history.
// ----------------------------------------------------------------------------
module tpp_encoder (
    input  tpp_pkg::in_item_t item,
    input  tpp_pkg::hist_t    prev,
    input  logic              xm_volume_mode,
    output tpp_pkg::enc_res_t res
);
    import tpp_pkg::*;

    logic [7:0]        empty_vol;
    logic              in_range;
    logic              is_empty;
    logic [7:0]        mask;
    logic              mask_chg;
    logic [7:0]        chan_byte;
    hist_t             nh;
    logic [BIDX_W-1:0] k;
    byte_vec_t         bl;

    assign empty_vol = xm_volume_mode ? VOL_EMPTY_XM : VOL_EMPTY_IT;
    assign in_range  = int'(item.channel) < NUM_CHANNELS;
    assign is_empty  = (item.note == NOTE_EMPTY) && (item.instrument == 8'd0)
                    && (item.volume == empty_vol) && (item.effect == 8'd0)
                    && (item.effect_param == 8'd0);

    // Mask and history update for a cell
    always_comb begin
        mask = 8'd0;
        nh   = prev;
        if (item.note != NOTE_EMPTY) begin
            mask[MB_NOTE]   = 1'b1;
            mask[MB_NOTE_P] = 1'b1;
        end
        if (item.instrument != 8'd0) begin
            mask[MB_INST]   = 1'b1;
            mask[MB_INST_P] = 1'b1;
        end
        if (item.note > NOTE_EMPTY) begin
            mask[MB_NOTE_P] = 1'b0;
            mask[MB_INST_P] = 1'b0;
        end
        if (item.volume != empty_vol) begin
            mask[MB_VOL]   = 1'b1;
            mask[MB_VOL_P] = 1'b1;
        end
        if ((item.effect != 8'd0) || (item.effect_param != 8'd0)) begin
            mask[MB_FX]   = 1'b1;
            mask[MB_FX_P] = 1'b1;
        end
        if (mask[MB_NOTE]) begin
            if ({1'b0, item.note} == prev.note) begin
                mask[MB_NOTE] = 1'b0;
            end else begin
                // note-off and note-cut are never remembered
                nh.note = ((item.note == NOTE_OFF) || (item.note == NOTE_CUT))
                        ? NONE_VAL : {1'b0, item.note};
            end
        end
        if (mask[MB_INST]) begin
            if ({1'b0, item.instrument} == prev.instrument) begin
                mask[MB_INST] = 1'b0;
            end else begin
                nh.instrument = {1'b0, item.instrument};
            end
        end
        if (mask[MB_VOL]) begin
            if ({1'b0, item.volume} == prev.volume) begin
                mask[MB_VOL] = 1'b0;
            end else begin
                nh.volume = {1'b0, item.volume};
            end
        end
        if (mask[MB_FX]) begin
            if (({1'b0, item.effect} == prev.effect)
                && ({1'b0, item.effect_param} == prev.effect_param)) begin
                mask[MB_FX] = 1'b0;
            end else begin
                nh.effect       = {1'b0, item.effect};
                nh.effect_param = {1'b0, item.effect_param};
            end
        end
        mask_chg = ({1'b0, mask} != prev.mask);
        if (mask_chg) begin
            nh.mask = {1'b0, mask};
        end
        chan_byte               = 8'(item.channel) + 8'd1;
        chan_byte[CB_MASK_FLAG] = chan_byte[CB_MASK_FLAG] | mask_chg;
    end

    // Byte list of a cell
    always_comb begin
        bl    = '0;
        k     = '0;
        bl[k] = chan_byte;
        k     = k + 1'b1;
        if (mask_chg) begin
            bl[k] = mask;
            k     = k + 1'b1;
        end
        if (mask[MB_NOTE]) begin
            bl[k] = item.note;
            k     = k + 1'b1;
        end
        if (mask[MB_INST]) begin
            bl[k] = item.instrument;
            k     = k + 1'b1;
        end
        if (mask[MB_VOL]) begin
            bl[k] = item.volume;
            k     = k + 1'b1;
        end
        if (mask[MB_FX]) begin
            bl[k] = item.effect;
            k     = k + 1'b1;
            bl[k] = item.effect_param;
            k     = k + 1'b1;
        end
    end

    always_comb begin
        res.bytes   = '0;
        res.count   = '0;
        res.wr_en   = 1'b0;
        res.clr_all = 1'b0;
        res.hist    = nh;
        case (item.op)
            OP_HEADER: begin
                res.bytes[0] = item.row_count[7:0] - 8'd1;
                res.count    = CNT_W'(1);
                res.clr_all  = 1'b1;
            end
            OP_ROW_END: begin
                res.bytes[0] = 8'd0;
                res.count    = CNT_W'(1);
            end
            OP_CLEAR: begin
                res.clr_all = 1'b1;
            end
            default: begin
                if (in_range && !is_empty) begin
                    res.bytes = bl;
                    // k never wraps: a full list of seven bytes leaves it at seven
                    res.count = (k == '0) ? CNT_W'(MAX_BYTES) : CNT_W'(k);
                    res.wr_en = 1'b1;
                end
            end
        endcase
    end

endmodule

### hw/rtl/tpp_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_serializer
// Holds one item's bytes; shifts out one byte per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module tpp_serializer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  tpp_pkg::byte_vec_t               bytes,
    input  logic [tpp_pkg::CNT_W-1:0]        count,
    output logic                             can_load,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tpp_pkg::out_item_t               m_data
);
    import tpp_pkg::*;

    byte_vec_t        buf_reg, buf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             take;

    assign m_valid  = (cnt_reg != '0);
    assign take     = m_valid && m_ready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = bytes;
            cnt_next = count;
        end else if (take) begin
            for (int i = 0; i < MAX_BYTES - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[MAX_BYTES-1] = 8'd0;
            cnt_next              = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign m_data.out_byte    = buf_reg[0];
    assign m_data.last_of_run = (cnt_reg == CNT_W'(1));

endmodule

### hw/rtl/tpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks of the tracker pattern packer, bound to the top level.
// ----------------------------------------------------------------------------
module tpp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input tpp_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input tpp_pkg::out_item_t m_data
);
    import tpp_pkg::*;

    // A waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while waiting");

    // A stalled byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output byte changed while stalled");

    // Bytes of one item go out without gaps
    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_run |=> m_valid)
        else $error("gap inside a byte run");

    // Reset empties the output
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Reset leaves the input open
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind tracker_pattern_packer tpp_checker u_tpp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

### verif/tracker_pattern_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pattern_packer_tb
// Self-checking bench for the tracker pattern packer. A short table of
// commands covers headers, row ends, history clears, full and empty cells and
// both empty-volume modes. Random pattern fragments follow, with a little
// noise mixed in. Every accepted command goes through a local packer model
// that keeps its own per-channel history. Each output byte and its end flag
// are compared in order. Both sides idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tracker_pattern_packer_tb;
    import tpp_pkg::*;

    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DIR_ROWS        = 25;

    // Remembered values of one channel, 9 bits each so that NONE_VAL fits.
    typedef struct packed {
        logic [8:0] mask;
        logic [8:0] note;
        logic [8:0] inst;
        logic [8:0] vol;
        logic [8:0] fx;
        logic [8:0] prm;
    } chan_memory_t;

    localparam chan_memory_t NO_HISTORY = '{default: NONE_VAL};

    // One row of the directed table. When typed is set, the bytes are
    // written out by hand; otherwise the packer model supplies them.
    typedef struct packed {
        logic            mode;
        logic            typed;
        logic [2:0]      n_bytes;
        logic [0:6][7:0] want_bytes;
        in_item_t        item;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    // Packer model state and the bytes still owed by the block.
    chan_memory_t chan_mem [NUM_CHANNELS];
    logic         xm_vol_mode;
    logic [7:0]   run_bytes [$];
    out_item_t    expected_bytes [$];
    int           mismatches = 0;

    // Idle control shared by the sender and the result side.
    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;
    bit rx_holding   = 1'b0;

    tracker_pattern_packer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Packer model
    // ------------------------------------------------------------------------
    function automatic void forget_history();
        foreach (chan_mem[i]) chan_mem[i] = NO_HISTORY;
    endfunction

    // Work out the bytes that one command produces into run_bytes, and
    // advance the channel history just as the block does.
    function automatic void pack_command(input in_item_t cmd);
        logic [7:0]   empty_vol;
        logic [8:0]   mask;
        logic [7:0]   chan_byte;
        logic         is_empty;
        chan_memory_t mem;
        run_bytes.delete();
        mask      = '0;
        empty_vol = xm_vol_mode ? VOL_EMPTY_XM : VOL_EMPTY_IT;
        is_empty  = (cmd.note == NOTE_EMPTY) && (cmd.instrument == 8'd0) &&
                    (cmd.volume == empty_vol) && (cmd.effect == 8'd0) &&
                    (cmd.effect_param == 8'd0);
        if (cmd.op == OP_HEADER) begin
            // A pattern's first row is always marked, so wipe every channel.
            forget_history();
            run_bytes.push_back(8'(cmd.row_count - 9'd1));
        end else if (cmd.op == OP_ROW_END) begin
            run_bytes.push_back(8'h00);
        end else if (cmd.op == OP_CLEAR) begin
            forget_history();
        end else if (int'(cmd.channel) < NUM_CHANNELS && !is_empty) begin
            mem = chan_mem[cmd.channel];
            if (cmd.note != NOTE_EMPTY) begin
                mask[MB_NOTE]   = 1'b1;
                mask[MB_NOTE_P] = 1'b1;
            end
            if (cmd.instrument != 8'd0) begin
                mask[MB_INST]   = 1'b1;
                mask[MB_INST_P] = 1'b1;
            end
            // Note-off, note-cut and the values above empty drop both
            // presence flags of note and instrument.
            if (cmd.note > NOTE_EMPTY) begin
                mask[MB_NOTE_P] = 1'b0;
                mask[MB_INST_P] = 1'b0;
            end
            if (cmd.volume != empty_vol) begin
                mask[MB_VOL]   = 1'b1;
                mask[MB_VOL_P] = 1'b1;
            end
            if (cmd.effect != 8'd0 || cmd.effect_param != 8'd0) begin
                mask[MB_FX]   = 1'b1;
                mask[MB_FX_P] = 1'b1;
            end
            // Drop whatever matches the channel's remembered value.
            if (mask[MB_NOTE]) begin
                if ({1'b0, cmd.note} == mem.note)
                    mask[MB_NOTE] = 1'b0;
                else if (cmd.note == NOTE_OFF || cmd.note == NOTE_CUT)
                    mem.note = NONE_VAL;
                else
                    mem.note = {1'b0, cmd.note};
            end
            if (mask[MB_INST]) begin
                if ({1'b0, cmd.instrument} == mem.inst)
                    mask[MB_INST] = 1'b0;
                else
                    mem.inst = {1'b0, cmd.instrument};
            end
            if (mask[MB_VOL]) begin
                if ({1'b0, cmd.volume} == mem.vol)
                    mask[MB_VOL] = 1'b0;
                else
                    mem.vol = {1'b0, cmd.volume};
            end
            if (mask[MB_FX]) begin
                if ({1'b0, cmd.effect} == mem.fx && {1'b0, cmd.effect_param} == mem.prm) begin
                    mask[MB_FX] = 1'b0;
                end else begin
                    mem.fx  = {1'b0, cmd.effect};
                    mem.prm = {1'b0, cmd.effect_param};
                end
            end
            chan_byte = {3'b000, cmd.channel} + 8'd1;
            if (mask != mem.mask) begin
                chan_byte[CB_MASK_FLAG] = 1'b1;
                mem.mask = mask;
            end
            chan_mem[cmd.channel] = mem;

            run_bytes.push_back(chan_byte);
            if (chan_byte[CB_MASK_FLAG]) run_bytes.push_back(mask[7:0]);
            if (mask[MB_NOTE])           run_bytes.push_back(cmd.note);
            if (mask[MB_INST])           run_bytes.push_back(cmd.instrument);
            if (mask[MB_VOL])            run_bytes.push_back(cmd.volume);
            if (mask[MB_FX]) begin
                run_bytes.push_back(cmd.effect);
                run_bytes.push_back(cmd.effect_param);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic in_item_t random_item();
        logic [63:0] raw;
        in_item_t    it;
        raw = {$urandom, $urandom};
        it  = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    // A cell whose values favor a few channels and repeat often, so that
    // the history comparisons hit both ways.
    function automatic in_item_t random_cell();
        in_item_t it;
        it         = random_item();
        it.op      = OP_CELL;
        it.channel = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
        case ($urandom_range(0, 7))
            0, 1:    it.note = NOTE_EMPTY;
            2:       it.note = NOTE_OFF;
            3:       it.note = NOTE_CUT;
            4, 5:    it.note = 8'(60 + $urandom_range(0, 1));
            default: it.note = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: it.instrument = 8'd0;
            3, 4, 5: it.instrument = 8'($urandom_range(1, 2));
            default: it.instrument = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: it.volume = xm_vol_mode ? VOL_EMPTY_XM : VOL_EMPTY_IT;
            3:       it.volume = xm_vol_mode ? VOL_EMPTY_IT : VOL_EMPTY_XM;
            4, 5:    it.volume = $urandom_range(0, 1) ? 8'd32 : 8'd64;
            default: it.volume = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                it.effect       = 8'd0;
                it.effect_param = 8'd0;
            end
            3, 4: begin
                it.effect       = 8'($urandom_range(1, 2));
                it.effect_param = 8'($urandom_range(0, 1));
            end
            5:       it.effect = 8'd0;
            default: ;
        endcase
        return it;
    endfunction

    function automatic stim_row_t stim_row(input logic mode, input logic typed,
                                           input logic [2:0] n, input logic [55:0] wb,
                                           input logic [1:0] op, input logic [4:0] ch,
                                           input logic [7:0] note, input logic [7:0] inst,
                                           input logic [7:0] vol, input logic [7:0] fx,
                                           input logic [7:0] prm, input logic [8:0] rows);
        stim_row_t r;
        r.mode                   = mode;
        r.typed                  = typed;
        r.n_bytes                = n;
        r.want_bytes             = wb;
        r.item.op                = op;
        r.item.channel           = ch;
        r.item.note              = note;
        r.item.instrument        = inst;
        r.item.volume            = vol;
        r.item.effect            = fx;
        r.item.effect_param      = prm;
        r.item.row_count         = rows;
        return r;
    endfunction

    // Offer one command after a random gap, hold it until it is taken, then
    // queue the bytes it owes. Typed rows replace the model's bytes but
    // still advance the model's history.
    task automatic send_item(input in_item_t it, input logic typed = 1'b0,
                             input int n_typed = 0,
                             input logic [0:6][7:0] typed_bytes = '0);
        int gap;
        gap = (no_idle || hold_off_req || rx_holding) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pack_command(it);
        if (typed) begin
            run_bytes.delete();
            for (int i = 0; i < n_typed; i++) run_bytes.push_back(typed_bytes[i]);
        end
        foreach (run_bytes[i])
            expected_bytes.push_back('{out_byte: run_bytes[i],
                                       last_of_run: (i == run_bytes.size() - 1)});
    endtask

    // Drop valid, wait for every owed byte, then give a command that emits
    // nothing time to leave the pipeline.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vol_mode(input logic mode);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        xm_vol_mode = mode;
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random gaps, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : drive_result_ready
        int run_len;
        int gap_len;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_off_req) begin
                // Hold off long enough for the block to fill and stall its input.
                hold_off_req = 1'b0;
                rx_holding   = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                rx_holding   = 1'b0;
            end
            run_len = no_idle ? 16 : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            gap_len = no_idle ? 0 : pick_gap();
            if (gap_len > 0) begin
                m_ready <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
    end

    // Compare each byte taken with the oldest one owed.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $time, m_data.out_byte, m_data.last_of_run);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.out_byte, m_data.out_byte);
                    mismatches++;
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                             $time, want.last_of_run, m_data.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // End the run when nothing moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles, %0d bytes still owed",
                 $time, WATCHDOG_LIMIT, expected_bytes.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        stim_row_t dir_tab [DIR_ROWS];
        in_item_t  it;
        int        sent;
        int        rows;
        int        cells;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        xm_vol_mode = 1'b0;
        forget_history();

        // Directed table. Columns: volume mode, typed, byte count, bytes,
        // then op, channel, note, instrument, volume, effect, param, rows.
        dir_tab = '{
            // Header row counts: ordinary, zero wraps, one, top of range.
            stim_row(0, 1, 1, 56'h3F_00_00_00_00_00_00, OP_HEADER,  0,   0,   0,   0,   0,   0,  64),
            stim_row(0, 1, 1, 56'hFF_00_00_00_00_00_00, OP_HEADER,  0,   0,   0,   0,   0,   0,   0),
            stim_row(0, 1, 1, 56'h00_00_00_00_00_00_00, OP_HEADER,  0,   0,   0,   0,   0,   0,   1),
            stim_row(0, 1, 1, 56'hFF_00_00_00_00_00_00, OP_HEADER,  0,   0,   0,   0,   0,   0, 256),
            stim_row(0, 1, 1, 56'hFE_00_00_00_00_00_00, OP_HEADER, 31, 255, 255, 255, 255, 255, 511),
            stim_row(0, 1, 1, 56'h00_00_00_00_00_00_00, OP_ROW_END, 0,   0,   0,   0,   0,   0,   0),
            // Fresh channel: note and instrument both sent with a new mask.
            stim_row(0, 1, 4, 56'h81_33_3C_01_00_00_00, OP_CELL,    0,  60,   1, 255,   0,   0,   0),
            stim_row(0, 0, 0, 56'h0,                    OP_CELL,    0,  60,   1, 255,   0,   0,   0),
            // Empty cell in the default volume mode.
            stim_row(0, 1, 0, 56'h0,                    OP_CELL,    5, 250,   0, 255,   0,   0,   0),
            // Top values but volume zero on the last channel: seven bytes.
            stim_row(0, 1, 7, 56'hA0_CF_FF_FF_00_FF_FF, OP_CELL,   31, 255, 255,   0, 255, 255,   0),
            // Cut and off are never remembered.
            stim_row(0, 0, 0, 56'h0,                    OP_CELL,   31, 255, 255,   0, 255, 255,   0),
            stim_row(0, 0, 0, 56'h0,                    OP_CELL,   31, 254, 255,   0, 255, 255,   0),
            stim_row(0, 0, 0, 56'h0,                    OP_CELL,    1,   0,   0, 128,   0,   1,   0),
            stim_row(0, 0, 0, 56'h0,                    OP_CELL,    3, 250,   0, 255,   0,  85,   0),
            stim_row(0, 0, 0, 56'h0,                    OP_CELL,    3, 251,   7,  64,   1,  85,   0),
            // Clear emits nothing; the same cell is then sent in full again.
            stim_row(0, 1, 0, 56'h0,                    OP_CLEAR,  31, 255, 255, 255, 255, 255, 511),
            stim_row(0, 1, 4, 56'h81_33_3C_01_00_00_00, OP_CELL,    0,  60,   1, 255,   0,   0,   0),
            stim_row(0, 1, 1, 56'h00_00_00_00_00_00_00, OP_ROW_END,31, 255, 255, 255, 255, 255, 511),
            stim_row(0, 0, 0, 56'h0,                    OP_CELL,    0,  60,   2,  10,  15,   0,   0),
            // Other volume mode: zero is now the empty volume.
            stim_row(1, 1, 0, 56'h0,                    OP_CELL,    0, 250,   0,   0,   0,   0,   0),
            stim_row(1, 1, 3, 56'h88_44_FF_00_00_00_00, OP_CELL,    7, 250,   0, 255,   0,   0,   0),
            stim_row(1, 0, 0, 56'h0,                    OP_CELL,    7, 250,   0, 255,   0,   0,   0),
            stim_row(1, 1, 1, 56'h01_00_00_00_00_00_00, OP_HEADER,  0,   0,   0,   0,   0,   0,   2),
            stim_row(1, 1, 3, 56'h88_44_FF_00_00_00_00, OP_CELL,    7, 250,   0, 255,   0,   0,   0),
            stim_row(1, 1, 0, 56'h0,                    OP_CELL,    7, 250,   0,   0,   0,   0,   0)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the table; change the volume mode only with the block idle.
        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != xm_vol_mode) write_vol_mode(dir_tab[i].mode);
            send_item(dir_tab[i].item, dir_tab[i].typed, int'(dir_tab[i].n_bytes),
                      dir_tab[i].want_bytes);
        end

        // Random phases alternate the volume mode. The second runs with no
        // idling at all, the third opens with the long hold-off.
        for (int phase = 0; phase < 4; phase++) begin
            write_vol_mode(phase[0]);
            no_idle = (phase == 1);
            if (phase == 2) hold_off_req = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any command with any content.
                    send_item(random_item());
                    sent++;
                end else begin
                    // Pattern fragment: header, a few rows of cells, row ends.
                    it = random_item();
                    it.op = OP_HEADER;
                    if ($urandom_range(0, 3) != 0) it.row_count = 9'($urandom_range(1, 64));
                    send_item(it);
                    sent++;
                    rows = $urandom_range(1, 4);
                    for (int r = 0; r < rows; r++) begin
                        cells = $urandom_range(0, 4);
                        for (int c = 0; c < cells; c++) begin
                            send_item(random_cell());
                            sent++;
                        end
                        if ($urandom_range(0, 15) == 0) begin
                            it = random_item();
                            it.op = OP_CLEAR;
                            send_item(it);
                            sent++;
                        end
                        it = random_item();
                        it.op = OP_ROW_END;
                        send_item(it);
                        sent++;
                    end
                end
            end
        end
        no_idle = 1'b0;

        settle_block();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tpp_pkg.sv
hw/rtl/tpp_hist_ram.sv
hw/rtl/tpp_encoder.sv
hw/rtl/tpp_serializer.sv
hw/rtl/tracker_pattern_packer.sv
hw/rtl/tpp_checker.sv
verif/tracker_pattern_packer_tb.sv
